@@ src/rwkv_pkg.sv @@
// ----------------------------------------------------------------------------
// rwkv_pkg
// shared types, constants and helpers for the wkv recurrence block
// ----------------------------------------------------------------------------
package rwkv_pkg;

  localparam int CHANNELS  = 1024;
  localparam int IDX_W     = $clog2(CHANNELS);
  localparam int EXP_STEPS = 16;
  localparam int EXP_LAT   = EXP_STEPS + 2;
  localparam int DIV_BITS  = 48;
  localparam int DIV_LAT   = DIV_BITS + 2;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [9:0]         channel;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic signed [31:0] bonus;
    logic signed [31:0] decay;
  } item_t;

  typedef struct packed {
    logic [9:0]         channel_out;
    logic signed [31:0] wkv;
  } result_t;

  typedef struct packed {
    logic signed [31:0] num_accum;
    logic signed [31:0] den_accum;
    logic signed [31:0] max_exponent;
  } state_t;

  typedef struct packed {
    logic neg;
    logic zero_den;
    logic a_pos;
    logic a_neg;
  } div_flags_t;

  localparam state_t ST_RESET = '{32'sd0, 32'sd0, S32_MIN};

  // round(2^30 * e^-n)
  localparam logic [30:0] EXP_INT [12] = '{
    31'd1073741824, 31'd395007542, 31'd145315154, 31'd53458458,
    31'd19666267,   31'd7234815,   31'd2661540,   31'd979126,
    31'd360200,     31'd132510,    31'd48748,     31'd17933
  };

  // round(2^30 * e^-(2^-j)), j = 1..16
  localparam logic [29:0] EXP_FRAC [EXP_STEPS] = '{
    30'd651257337,  30'd836230973,  30'd947573834,  30'd1008687096,
    30'd1040706261, 30'd1057095000, 30'd1065385899, 30'd1069555701,
    30'd1071646719, 30'd1072693760, 30'd1073217664, 30'd1073479712,
    30'd1073610760, 30'd1073676290, 30'd1073709056, 30'd1073725440
  };

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'(S32_MAX)) return S32_MAX;
    if (x < 64'(S32_MIN)) return S32_MIN;
    return x[31:0];
  endfunction

  function automatic idx_t chan_idx(input logic [9:0] c);
    return IDX_W'(32'(c) % CHANNELS);
  endfunction

endpackage

@@ src/rwkv_exp.sv @@
// ----------------------------------------------------------------------------
// rwkv_exp
// pipelined exp of a non-positive q16.16 word, one table multiply per stage
// ----------------------------------------------------------------------------
module rwkv_exp import rwkv_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [32:0] mag,
  output logic [16:0] e
);

  logic [30:0] acc  [EXP_STEPS+1];
  logic [15:0] frac [EXP_STEPS];
  logic [30:0] rnd;

  function automatic logic [30:0] fstep(input logic [30:0] a, input logic [29:0] c);
    logic [60:0] prod;
    prod = 61'(a) * 61'(c);
    prod = prod + 61'h2000_0000;
    return prod[60:30];
  endfunction

  assign rnd = acc[EXP_STEPS] + 31'd8192;

  always_ff @(posedge clk) begin
    if (en) begin
      if (mag[32:16] >= 17'd12) begin
        acc[0] <= '0;
      end else begin
        acc[0] <= EXP_INT[mag[19:16]];
      end
      frac[0] <= mag[15:0];
      for (int s = 1; s <= EXP_STEPS; s++) begin
        acc[s] <= frac[s-1][EXP_STEPS-s] ? fstep(acc[s-1], EXP_FRAC[s-1]) : acc[s-1];
      end
      for (int s = 1; s < EXP_STEPS; s++) begin
        frac[s] <= frac[s-1];
      end
      e <= rnd[30:14];
    end
  end

endmodule

@@ src/rwkv_div.sv @@
// ----------------------------------------------------------------------------
// rwkv_div
// pipelined signed q16.16 divide, one quotient bit per stage, saturating
// ----------------------------------------------------------------------------
module rwkv_div import rwkv_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] q
);

  logic [31:0]         rem  [DIV_BITS+1];
  logic [DIV_BITS-1:0] num  [DIV_BITS+1];
  logic [31:0]         den  [DIV_BITS+1];
  div_flags_t          flg  [DIV_BITS+1];
  logic [32:0]         tr   [DIV_BITS];
  logic                ge   [DIV_BITS];
  logic [32:0]         diff [DIV_BITS];
  logic [31:0]         a_mag, b_mag;
  logic signed [31:0]  q_next;

  assign a_mag = a[31] ? (~a + 32'd1) : a;
  assign b_mag = b[31] ? (~b + 32'd1) : b;

  always_comb begin
    for (int s = 0; s < DIV_BITS; s++) begin
      tr[s]   = {rem[s], num[s][DIV_BITS-1]};
      ge[s]   = tr[s] >= {1'b0, den[s]};
      diff[s] = tr[s] - {1'b0, den[s]};
    end
  end

  always_comb begin
    if (flg[DIV_BITS].zero_den) begin
      if (flg[DIV_BITS].a_pos) begin
        q_next = S32_MAX;
      end else if (flg[DIV_BITS].a_neg) begin
        q_next = S32_MIN;
      end else begin
        q_next = '0;
      end
    end else if (flg[DIV_BITS].neg) begin
      if (num[DIV_BITS] > DIV_BITS'(33'h0_8000_0000)) begin
        q_next = S32_MIN;
      end else begin
        q_next = ~num[DIV_BITS][31:0] + 32'd1;
      end
    end else begin
      if (num[DIV_BITS] > DIV_BITS'(33'h0_7FFF_FFFF)) begin
        q_next = S32_MAX;
      end else begin
        q_next = num[DIV_BITS][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num[0] <= {a_mag, 16'd0};
      rem[0] <= '0;
      den[0] <= b_mag;
      flg[0] <= '{neg: a[31] ^ b[31], zero_den: b == 32'sd0,
                  a_pos: a > 32'sd0, a_neg: a[31]};
      for (int s = 1; s <= DIV_BITS; s++) begin
        rem[s] <= ge[s-1] ? diff[s-1][31:0] : tr[s-1][31:0];
        num[s] <= {num[s-1][DIV_BITS-2:0], ge[s-1]};
        den[s] <= den[s-1];
        flg[s] <= flg[s-1];
      end
      q <= q_next;
    end
  end

endmodule

@@ src/rwkv_wkv_recurrence.sv @@
// ----------------------------------------------------------------------------
// rwkv_wkv_recurrence
// rwkv-4 wkv recurrence per channel, q16.16, state held in one memory
// ----------------------------------------------------------------------------
//  port group     dir   word      accepted when
//  item           in    item_t    item_valid & item_ready
//  result         out   result_t  result_valid & result_ready
//
//  one word per cycle when not held by a hazard, clearing or a parked result
//  a word for a channel still in the first 23 stages (read to write-back of
//  the state memory) is held off until that channel has been written back
//  after reset a clearing pass fills the state memory
//  a stalled result parks in a skid register; the whole pipe then holds
// ----------------------------------------------------------------------------
module rwkv_wkv_recurrence import rwkv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int MUL  = 3 + EXP_LAT;
  localparam int WB   = MUL + 1;
  localparam int LAST = WB + DIV_LAT;

  typedef struct packed {
    logic signed [31:0] p2;
    logic signed [31:0] v;
    logic signed [31:0] aa;
    logic signed [31:0] bb;
  } side_t;

  state_t mem [CHANNELS];
  state_t rd;

  logic            clr_busy;
  idx_t            clr_addr;
  logic            adv, hazard, take, push;
  logic [LAST:0]   vld;
  logic [9:0]      ch [LAST+1];

  item_t s0;

  logic signed [31:0] s1_ww1, s1_ww2, s1_pp, s1_k, s1_v, s1_aa, s1_bb;
  logic signed [31:0] ww1_next, ww2_next;

  logic [32:0] s2_m1a, s2_m1b, s2_m2a, s2_m2b;
  logic [32:0] m1a_next, m1b_next, m2a_next, m2b_next;
  side_t       s2_sd, s2_sd_next;
  side_t       sd [EXP_LAT];

  logic [16:0] e1a, e2a, e1b, e2b;

  logic signed [49:0] pa1, pa2, pb1, pn1, pn2, pd1;
  logic [16:0]        m_e2a, m_e2b;
  side_t              m_sd;

  logic signed [31:0] a_r, b_r, a_next, b_next;
  state_t             wb, wb_next;
  logic signed [31:0] q;

  logic    skid_valid;
  result_t skid, res_new;

  assign adv        = !skid_valid;
  assign item_ready = adv && !clr_busy && !hazard;
  assign take       = item_valid && item_ready;
  assign push       = adv && vld[LAST];
  assign res_new    = '{channel_out: ch[LAST], wkv: q};

  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i <= WB; i++) begin
      if (vld[i] && chan_idx(ch[i]) == chan_idx(item.channel)) hazard = 1'b1;
    end
  end

  // clearing pass and state memory
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_W'(CHANNELS - 1)) clr_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= ST_RESET;
    end else if (vld[WB]) begin
      mem[chan_idx(ch[WB])] <= wb;
    end
    if (adv) rd <= mem[chan_idx(item.channel)];
  end

  // exponent bookkeeping
  always_comb begin
    ww1_next = sat32(64'(33'(s0.bonus) + 33'(s0.key)));
    ww2_next = sat32(64'(33'(rd.max_exponent) + 33'(s0.decay)));
  end

  always_comb begin
    m1a_next   = '0;
    m1b_next   = '0;
    m2a_next   = '0;
    m2b_next   = '0;
    s2_sd_next = '{p2: s1_k, v: s1_v, aa: s1_aa, bb: s1_bb};
    if (s1_pp > s1_ww1) begin
      m1b_next = 33'(s1_pp) - 33'(s1_ww1);
    end else begin
      m1a_next = 33'(s1_ww1) - 33'(s1_pp);
    end
    if (s1_ww2 > s1_k) begin
      m2b_next      = 33'(s1_ww2) - 33'(s1_k);
      s2_sd_next.p2 = s1_ww2;
    end else begin
      m2a_next = 33'(s1_k) - 33'(s1_ww2);
    end
  end

  rwkv_exp u_exp_1a (.clk(clk), .en(adv), .mag(s2_m1a), .e(e1a));
  rwkv_exp u_exp_2a (.clk(clk), .en(adv), .mag(s2_m1b), .e(e2a));
  rwkv_exp u_exp_1b (.clk(clk), .en(adv), .mag(s2_m2a), .e(e1b));
  rwkv_exp u_exp_2b (.clk(clk), .en(adv), .mag(s2_m2b), .e(e2b));

  // floor shift and saturate of the mixed sums
  always_comb begin
    logic signed [50:0] sa, sb, sn, sdn;
    sa  = 51'(pa1) + 51'(pa2);
    sb  = 51'(pb1) + 51'($signed({1'b0, m_e2a, 16'd0}));
    sn  = 51'(pn1) + 51'(pn2);
    sdn = 51'(pd1) + 51'($signed({1'b0, m_e2b, 16'd0}));
    a_next  = sat32(64'(sa >>> 16));
    b_next  = sat32(64'(sb >>> 16));
    wb_next = '{num_accum: sat32(64'(sn >>> 16)), den_accum: sat32(64'(sdn >>> 16)),
                max_exponent: m_sd.p2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ch[0] <= item.channel;
      for (int i = 1; i <= LAST; i++) ch[i] <= ch[i-1];
      s0 <= item;

      s1_ww1 <= ww1_next;
      s1_ww2 <= ww2_next;
      s1_pp  <= rd.max_exponent;
      s1_k   <= s0.key;
      s1_v   <= s0.value;
      s1_aa  <= rd.num_accum;
      s1_bb  <= rd.den_accum;

      s2_m1a <= m1a_next;
      s2_m1b <= m1b_next;
      s2_m2a <= m2a_next;
      s2_m2b <= m2b_next;
      s2_sd  <= s2_sd_next;

      sd[0] <= s2_sd;
      for (int i = 1; i < EXP_LAT; i++) sd[i] <= sd[i-1];

      pa1   <= 50'($signed({1'b0, e1a})) * 50'(sd[EXP_LAT-1].aa);
      pa2   <= 50'($signed({1'b0, e2a})) * 50'(sd[EXP_LAT-1].v);
      pb1   <= 50'($signed({1'b0, e1a})) * 50'(sd[EXP_LAT-1].bb);
      pn1   <= 50'($signed({1'b0, e1b})) * 50'(sd[EXP_LAT-1].aa);
      pn2   <= 50'($signed({1'b0, e2b})) * 50'(sd[EXP_LAT-1].v);
      pd1   <= 50'($signed({1'b0, e1b})) * 50'(sd[EXP_LAT-1].bb);
      m_e2a <= e2a;
      m_e2b <= e2b;
      m_sd  <= sd[EXP_LAT-1];

      a_r <= a_next;
      b_r <= b_next;
      wb  <= wb_next;
    end
  end

  rwkv_div u_div (.clk(clk), .en(adv), .a(a_r), .b(b_r), .q(q));

  // output word and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_valid && result_ready) begin
      if (skid_valid) begin
        result     <= skid;
        skid_valid <= 1'b0;
      end else if (push) begin
        result <= res_new;
      end else begin
        result_valid <= 1'b0;
      end
    end else if (!result_valid) begin
      if (push) begin
        result       <= res_new;
        result_valid <= 1'b1;
      end
    end else if (push) begin
      skid       <= res_new;
      skid_valid <= 1'b1;
    end
  end

endmodule
